// ===== rtl/lbcs_pkg.sv =====
`timescale 1ns / 1ps

package lbcs_pkg;

	localparam int BLK_COUNT_DEF   = 256;
	localparam int BLOCK_BYTES_DEF = 64;
	localparam logic [8:0] BIU_RESET = 9'd256;

	localparam logic [2:0] CMD_ALLOC = 3'd0;
	localparam logic [2:0] CMD_SETLEN = 3'd1;
	localparam logic [2:0] CMD_WRITE = 3'd2;
	localparam logic [2:0] CMD_READ = 3'd3;
	localparam logic [2:0] CMD_CLEAR = 3'd4;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NO_FREE = 2'd1;
	localparam logic [1:0] ST_BEYOND = 2'd2;

	typedef struct packed {
		logic [2:0]  command;
		logic [7:0]  head_blk;
		logic [13:0] position;
		logic [14:0] length;
		logic [7:0]  data_byte;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] block_index;
		logic [7:0] read_data;
	} rsp_t;

endpackage

// ===== rtl/linked_block_chain_store.sv =====
`timescale 1ns / 1ps

// Linked block chain store: a link table (free / end of chain / next block)
// and a byte store of BLOCK_BYTES bytes per block.
// Command channel: an item (req) is taken at a clock edge with start high and
// busy low. Exactly one result per item appears on rsp for one cycle, marked
// by done; the receiver cannot stall it. A new item may start in the cycle
// that done is shown.
// Config channel: cfg_valid/cfg_ready write blocks_in_use; always ready.
// One shared sequencer, with a registered read on each memory. A read/write
// walks position/BLOCK_BYTES links of the chain, allocate scans blocks from 0
// up to the blocks_in_use limit, set length walks, claims or frees chain
// blocks plus the scans, and clear data zeroes every byte of each block of
// the chain.
// Reset: a clearing pass over every byte zeroes the byte store and frees
// every link; busy stays high until it is finished.
module linked_block_chain_store #(
	parameter int BLK_COUNT   = lbcs_pkg::BLK_COUNT_DEF,
	parameter int BLOCK_BYTES = lbcs_pkg::BLOCK_BYTES_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  lbcs_pkg::req_t  req,
	output logic            done,
	output lbcs_pkg::rsp_t  rsp,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [8:0]      cfg_data
);

	localparam int BW   = (BLK_COUNT > 1) ? $clog2(BLK_COUNT) : 1;
	localparam int CW   = BW + 1;
	localparam int LW   = $clog2(BLK_COUNT + 2);
	localparam int OW   = $clog2(BLOCK_BYTES);
	localparam int SW   = $clog2(BLK_COUNT * BLOCK_BYTES);
	localparam int LIMW = (CW > 9) ? CW : 9;
	localparam int SD   = BLK_COUNT * BLOCK_BYTES;

	localparam logic [LW-1:0] LINK_END  = LW'(BLK_COUNT);
	localparam logic [LW-1:0] LINK_FREE = LW'(BLK_COUNT + 1);

	localparam logic [4:0] S_INIT    = 5'd0;
	localparam logic [4:0] S_IDLE    = 5'd1;
	localparam logic [4:0] S_W_RD    = 5'd2;
	localparam logic [4:0] S_W_EV    = 5'd3;
	localparam logic [4:0] S_BYTE    = 5'd4;
	localparam logic [4:0] S_B_EV    = 5'd5;
	localparam logic [4:0] S_SC_RD   = 5'd6;
	localparam logic [4:0] S_SC_EV   = 5'd7;
	localparam logic [4:0] S_SL_LINK = 5'd8;
	localparam logic [4:0] S_SL0_RD  = 5'd9;
	localparam logic [4:0] S_SL0_EV  = 5'd10;
	localparam logic [4:0] S_SL_RD   = 5'd11;
	localparam logic [4:0] S_SL_EV   = 5'd12;
	localparam logic [4:0] S_TL_RD   = 5'd13;
	localparam logic [4:0] S_TL_EV   = 5'd14;
	localparam logic [4:0] S_TF_CHK  = 5'd15;
	localparam logic [4:0] S_TF_EV   = 5'd16;
	localparam logic [4:0] S_CLR     = 5'd17;
	localparam logic [4:0] S_CL_RD   = 5'd18;
	localparam logic [4:0] S_CL_EV   = 5'd19;

	logic [4:0]      state_q;
	logic [2:0]      cmd_q;
	logic [7:0]      dat_q;
	logic [14:0]     rem_q;
	logic [BW-1:0]   cur_q;
	logic [OW-1:0]   off_q;
	logic [CW-1:0]   cnt_q;
	logic [LIMW-1:0] scan_q;
	logic [LW-1:0]   t_q;
	logic [8:0]      biu_q;
	logic            done_q;
	lbcs_pkg::rsp_t  rsp_q;

	logic [LW-1:0] lt_mem [BLK_COUNT];
	logic [LW-1:0] lt_rd_q;
	logic [BW-1:0] lt_ra;
	logic          lt_we;
	logic [BW-1:0] lt_wa;
	logic [LW-1:0] lt_wd;

	logic [7:0]    bs_mem [SD];
	logic [7:0]    bs_rd_q;
	logic [SW-1:0] bs_addr;
	logic          bs_we;
	logic [7:0]    bs_wd;

	logic [LIMW-1:0] limit;
	logic            head_ok;
	logic            nx_end;
	logic            off_last;

	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign done      = done_q;
	assign rsp       = rsp_q;

	assign limit = (LIMW'(biu_q) > LIMW'(BLK_COUNT)) ? LIMW'(BLK_COUNT) : LIMW'(biu_q);
	assign head_ok  = (32'(req.head_blk) < BLK_COUNT);
	assign nx_end   = (lt_rd_q >= LINK_END);
	assign off_last = (off_q == OW'(BLOCK_BYTES - 1));
	assign bs_addr  = SW'(SW'(cur_q) * SW'(BLOCK_BYTES) + SW'(off_q));

	always_comb begin
		lt_ra = cur_q;
		if (state_q == S_SC_RD) begin
			lt_ra = BW'(scan_q);
		end else if (state_q == S_TF_CHK) begin
			lt_ra = BW'(t_q);
		end
	end

	always_comb begin
		lt_we = 1'b0;
		lt_wa = cur_q;
		lt_wd = LINK_END;
		bs_we = 1'b0;
		bs_wd = 8'd0;
		unique case (state_q)
			S_INIT: begin
				lt_we = 1'b1;
				lt_wd = LINK_FREE;
				bs_we = 1'b1;
			end
			S_BYTE: begin
				bs_we = (cmd_q == lbcs_pkg::CMD_WRITE);
				bs_wd = dat_q;
			end
			S_SC_EV: begin
				lt_we = (lt_rd_q == LINK_FREE);
				lt_wa = BW'(scan_q);
			end
			S_SL_LINK: begin
				lt_we = 1'b1;
				lt_wd = LW'(scan_q);
			end
			S_SL0_EV: begin
				lt_we = (lt_rd_q == LINK_FREE);
			end
			S_TF_CHK: begin
				// leaving the free loop: cut the chain at its new end
				lt_we = !((t_q < LINK_END) && (cnt_q < CW'(BLK_COUNT)));
			end
			S_TF_EV: begin
				lt_we = 1'b1;
				lt_wa = BW'(t_q);
				lt_wd = LINK_FREE;
			end
			S_CLR: begin
				bs_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (lt_we) begin
			lt_mem[lt_wa] <= lt_wd;
		end
		lt_rd_q <= lt_mem[lt_ra];
	end

	always_ff @(posedge clk) begin
		if (bs_we) begin
			bs_mem[bs_addr] <= bs_wd;
		end
		bs_rd_q <= bs_mem[bs_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			cur_q   <= '0;
			off_q   <= '0;
			cnt_q   <= '0;
			scan_q  <= '0;
			biu_q   <= lbcs_pkg::BIU_RESET;
			done_q  <= 1'b0;
			cmd_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (cfg_valid) begin
				biu_q <= cfg_data;
			end
			unique case (state_q)
				S_INIT: begin
					off_q <= off_q + 1'b1;
					if (off_last) begin
						off_q <= '0;
						cur_q <= cur_q + 1'b1;
						if (cur_q == BW'(BLK_COUNT - 1)) begin
							cur_q   <= '0;
							state_q <= S_IDLE;
						end
					end
				end
				S_IDLE: begin
					if (start) begin
						cmd_q  <= req.command;
						dat_q  <= req.data_byte;
						cur_q  <= BW'(req.head_blk);
						cnt_q  <= '0;
						scan_q <= '0;
						off_q  <= '0;
						rsp_q  <= '0;
						if (req.command == lbcs_pkg::CMD_SETLEN) begin
							rem_q <= req.length;
						end else begin
							rem_q <= 15'(req.position);
						end
						case (req.command)
							lbcs_pkg::CMD_ALLOC: state_q <= S_SC_RD;
							lbcs_pkg::CMD_SETLEN, lbcs_pkg::CMD_WRITE, lbcs_pkg::CMD_READ,
							lbcs_pkg::CMD_CLEAR: begin
								if (!head_ok) begin
									rsp_q.status <= lbcs_pkg::ST_BEYOND;
									done_q       <= 1'b1;
								end else if (req.command == lbcs_pkg::CMD_SETLEN) begin
									state_q <= S_SL0_RD;
								end else if (req.command == lbcs_pkg::CMD_CLEAR) begin
									state_q <= S_CLR;
								end else begin
									state_q <= S_W_RD;
								end
							end
							default: done_q <= 1'b1;
						endcase
					end
				end
				S_W_RD: begin
					if (rem_q < 15'(BLOCK_BYTES)) begin
						off_q   <= OW'(rem_q);
						state_q <= S_BYTE;
					end else if (cnt_q == CW'(BLK_COUNT)) begin
						rsp_q.status <= lbcs_pkg::ST_BEYOND;
						done_q       <= 1'b1;
						state_q      <= S_IDLE;
					end else begin
						state_q <= S_W_EV;
					end
				end
				S_W_EV: begin
					if (nx_end) begin
						rsp_q.status <= lbcs_pkg::ST_BEYOND;
						done_q       <= 1'b1;
						state_q      <= S_IDLE;
					end else begin
						cur_q   <= BW'(lt_rd_q);
						rem_q   <= rem_q - 15'(BLOCK_BYTES);
						cnt_q   <= cnt_q + 1'b1;
						state_q <= S_W_RD;
					end
				end
				S_BYTE: begin
					if (cmd_q == lbcs_pkg::CMD_WRITE) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_B_EV;
					end
				end
				S_B_EV: begin
					rsp_q.read_data <= bs_rd_q;
					done_q          <= 1'b1;
					state_q         <= S_IDLE;
				end
				S_SC_RD: begin
					if (scan_q >= limit) begin
						rsp_q.status <= lbcs_pkg::ST_NO_FREE;
						done_q       <= 1'b1;
						state_q      <= S_IDLE;
					end else begin
						state_q <= S_SC_EV;
					end
				end
				S_SC_EV: begin
					if (lt_rd_q == LINK_FREE) begin
						if (cmd_q == lbcs_pkg::CMD_ALLOC) begin
							rsp_q.block_index <= 8'(scan_q);
							done_q            <= 1'b1;
							state_q           <= S_IDLE;
						end else begin
							state_q <= S_SL_LINK;
						end
					end else begin
						scan_q  <= scan_q + 1'b1;
						state_q <= S_SC_RD;
					end
				end
				S_SL_LINK: begin
					cur_q   <= BW'(scan_q);
					rem_q   <= rem_q - 15'(BLOCK_BYTES);
					state_q <= S_SL_RD;
				end
				S_SL0_RD: state_q <= S_SL0_EV;
				S_SL0_EV: state_q <= S_SL_RD;
				S_SL_RD: begin
					// more than one block still wanted
					if (rem_q > 15'(BLOCK_BYTES)) begin
						state_q <= S_SL_EV;
					end else begin
						state_q <= S_TL_RD;
					end
				end
				S_SL_EV: begin
					if (nx_end) begin
						scan_q  <= '0;
						state_q <= S_SC_RD;
					end else begin
						cur_q   <= BW'(lt_rd_q);
						rem_q   <= rem_q - 15'(BLOCK_BYTES);
						state_q <= S_SL_RD;
					end
				end
				S_TL_RD: state_q <= S_TL_EV;
				S_TL_EV: begin
					t_q     <= lt_rd_q;
					cnt_q   <= '0;
					state_q <= S_TF_CHK;
				end
				S_TF_CHK: begin
					if ((t_q < LINK_END) && (cnt_q < CW'(BLK_COUNT))) begin
						state_q <= S_TF_EV;
					end else begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_TF_EV: begin
					t_q     <= lt_rd_q;
					cnt_q   <= cnt_q + 1'b1;
					state_q <= S_TF_CHK;
				end
				S_CLR: begin
					off_q <= off_q + 1'b1;
					if (off_last) begin
						off_q   <= '0;
						state_q <= S_CL_RD;
					end
				end
				S_CL_RD: state_q <= S_CL_EV;
				S_CL_EV: begin
					cnt_q <= cnt_q + 1'b1;
					if (nx_end || (cnt_q == CW'(BLK_COUNT - 1))) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						cur_q   <= BW'(lt_rd_q);
						state_q <= S_CLR;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== tb/tb_linked_block_chain_store.sv =====
`timescale 1ns / 1ps

module tb_linked_block_chain_store;

	localparam int NB = lbcs_pkg::BLK_COUNT_DEF;
	localparam int BB = lbcs_pkg::BLOCK_BYTES_DEF;
	localparam logic [8:0] LINK_END = 9'(NB);
	localparam logic [8:0] LINK_FREE = 9'(NB + 1);
	localparam logic [2:0] CMD_BAD_LO = 3'd5;
	localparam logic [2:0] CMD_BAD_HI = 3'd7;
	localparam int CYCLE_LIMIT = 20000000;
	localparam int RANDOM_ITEMS = 1830;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	lbcs_pkg::req_t req;
	logic done;
	lbcs_pkg::rsp_t rsp;
	logic cfg_valid;
	logic cfg_ready;
	logic [8:0] cfg_data;

	linked_block_chain_store i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .rsp(rsp), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	typedef struct {
		lbcs_pkg::rsp_t rsp;
		bit             pinned;
		lbcs_pkg::rsp_t typed;
	} pending_t;

	typedef struct {
		bit             do_cfg;
		logic [8:0]     cfg;
		lbcs_pkg::req_t r;
		bit             pinned;
		lbcs_pkg::rsp_t typed;
	} row_t;

	// shadow of the block
	logic [8:0] scan_limit;
	logic [8:0] links [NB];
	logic [7:0] bytes [NB * BB];

	pending_t pending_q [$];
	pending_t pin_q [$];
	row_t rows [$];
	logic [7:0] heads [$];
	int errors;
	int cycles;
	int results_seen;
	int n_items;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want,
			results_seen);
		errors++;
	endtask

	function automatic bit claim_free(output logic [7:0] got);
		int lim;
		lim = scan_limit > NB ? NB : scan_limit;
		for (int b = 0; b < lim; b++) begin
			if (links[b] == LINK_FREE) begin
				links[b] = LINK_END;
				got = 8'(b);
				return 1'b1;
			end
		end
		got = '0;
		return 1'b0;
	endfunction

	function automatic logic [1:0] resize_chain(logic [7:0] head, int len);
		int want;
		int steps;
		logic [8:0] cur;
		logic [8:0] nx;
		logic [8:0] t;
		logic [7:0] got;
		want = (len + BB - 1) / BB;
		if (want == 0) want = 1;
		if (links[head] == LINK_FREE) links[head] = LINK_END;
		cur = 9'(head);
		while (want > 1) begin
			nx = links[cur];
			if (nx >= NB) begin
				if (!claim_free(got)) return lbcs_pkg::ST_NO_FREE;
				links[cur] = 9'(got);
				nx = 9'(got);
			end
			cur = nx;
			want--;
		end
		t = links[cur];
		steps = 0;
		while (t < NB && steps < NB) begin
			nx = links[t];
			links[t] = LINK_FREE;
			t = nx;
			steps++;
		end
		links[cur] = LINK_END;
		return lbcs_pkg::ST_OK;
	endfunction

	function automatic lbcs_pkg::rsp_t predict_command(lbcs_pkg::req_t r);
		lbcs_pkg::rsp_t o;
		logic [7:0] got;
		logic [8:0] cur;
		int hops;
		bit ok;
		o = '0;
		case (r.command)
			lbcs_pkg::CMD_ALLOC: begin
				if (claim_free(got)) o.block_index = got;
				else o.status = lbcs_pkg::ST_NO_FREE;
			end
			lbcs_pkg::CMD_SETLEN: o.status = resize_chain(r.head_blk, r.length);
			lbcs_pkg::CMD_CLEAR: begin
				cur = 9'(r.head_blk);
				for (int s = 0; s < NB; s++) begin
					for (int k = 0; k < BB; k++) bytes[cur * BB + k] = '0;
					if (links[cur] >= NB) break;
					cur = links[cur];
				end
			end
			lbcs_pkg::CMD_WRITE, lbcs_pkg::CMD_READ: begin
				hops = r.position / BB;
				cur = 9'(r.head_blk);
				ok = hops <= NB;
				for (int i = 0; ok && i < hops; i++) begin
					if (links[cur] >= NB) ok = 1'b0;
					else cur = links[cur];
				end
				if (!ok) o.status = lbcs_pkg::ST_BEYOND;
				else if (r.command == lbcs_pkg::CMD_WRITE)
					bytes[cur * BB + r.position % BB] = r.data_byte;
				else o.read_data = bytes[cur * BB + r.position % BB];
			end
			default: ;
		endcase
		return o;
	endfunction

	// acceptance, config writes and result checking
	always @(posedge clk) begin
		pending_t p;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("== FAIL ==");
			$finish;
		end else begin
			if (done) begin
				results_seen++;
				if (pending_q.size() == 0) begin
					$display("result with no item outstanding");
					errors++;
				end else begin
					p = pending_q.pop_front();
					if (rsp.status !== p.rsp.status) report("status", rsp.status, p.rsp.status);
					if (rsp.block_index !== p.rsp.block_index)
						report("block_index", rsp.block_index, p.rsp.block_index);
					if (rsp.read_data !== p.rsp.read_data)
						report("read_data", rsp.read_data, p.rsp.read_data);
					if (p.pinned && p.typed !== p.rsp)
						report("table row", int'(p.rsp), int'(p.typed));
				end
			end
			if (arst_n && cfg_valid && cfg_ready) scan_limit = cfg_data;
			if (arst_n && start && !busy) begin
				p = pin_q.pop_front();
				p.rsp = predict_command(req);
				pending_q.push_back(p);
			end
		end
	end

	task automatic idle_gap();
		if (!(n_items > 700 && n_items < 1000) && $urandom_range(99) < 30) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic send(lbcs_pkg::req_t r, bit pinned, lbcs_pkg::rsp_t typed);
		pending_t p;
		idle_gap();
		p.rsp = '0;
		p.pinned = pinned;
		p.typed = typed;
		pin_q.push_back(p);
		start <= 1'b1;
		req <= r;
		do @(posedge clk); while (busy);
		n_items++;
	endtask

	task automatic write_limit(logic [8:0] v);
		start <= 1'b0;
		@(posedge clk);
		while (pending_q.size() != 0 || pin_q.size() != 0) @(posedge clk);
		if ($urandom_range(99) < 30) repeat ($urandom_range(1, 6)) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	function automatic void add_row(bit do_cfg, logic [8:0] cfg, logic [2:0] c,
		logic [7:0] h, logic [13:0] pos, logic [14:0] len, logic [7:0] d,
		bit pinned, logic [1:0] st, logic [7:0] bi, logic [7:0] rd);
		row_t w;
		w.do_cfg = do_cfg;
		w.cfg = cfg;
		w.r = '{command: c, head_blk: h, position: pos, length: len, data_byte: d};
		w.pinned = pinned;
		w.typed = '{status: st, block_index: bi, read_data: rd};
		rows.push_back(w);
	endfunction

	initial begin
		lbcs_pkg::req_t r;
		int pick;
		start <= 1'b0;
		req <= '0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		arst_n <= 1'b0;
		scan_limit = lbcs_pkg::BIU_RESET;
		for (int i = 0; i < NB; i++) links[i] = LINK_FREE;
		for (int i = 0; i < NB * BB; i++) bytes[i] = '0;

		// after reset: empty store, lowest blocks handed out first
		add_row(0, 0, lbcs_pkg::CMD_READ, 0, 0, 0, 0, 1, lbcs_pkg::ST_OK, 0, 0);
		add_row(0, 0, lbcs_pkg::CMD_ALLOC, 0, 0, 0, 0, 1, lbcs_pkg::ST_OK, 0, 0);
		add_row(0, 0, lbcs_pkg::CMD_ALLOC, 0, 0, 0, 0, 1, lbcs_pkg::ST_OK, 1, 0);
		add_row(0, 0, lbcs_pkg::CMD_WRITE, 0, 0, 0, 8'hFF, 1, lbcs_pkg::ST_OK, 0, 0);
		add_row(0, 0, lbcs_pkg::CMD_READ, 0, 0, 0, 0, 1, lbcs_pkg::ST_OK, 0, 8'hFF);
		add_row(0, 0, lbcs_pkg::CMD_READ, 0, 14'd64, 0, 0, 1, lbcs_pkg::ST_BEYOND, 0, 0);
		add_row(0, 0, lbcs_pkg::CMD_WRITE, 0, 14'h3FFF, 0, 8'h5A, 1,
			lbcs_pkg::ST_BEYOND, 0, 0);
		add_row(0, 0, lbcs_pkg::CMD_SETLEN, 0, 0, 15'd16384, 0, 0, 0, 0, 0);
		add_row(0, 0, lbcs_pkg::CMD_SETLEN, 0, 0, 15'd0, 0, 0, 0, 0, 0);
		add_row(0, 0, lbcs_pkg::CMD_SETLEN, 8'd255, 0, 15'd130, 0, 0, 0, 0, 0);
		add_row(0, 0, lbcs_pkg::CMD_WRITE, 8'd255, 14'd129, 0, 8'hA5, 0, 0, 0, 0);
		add_row(0, 0, lbcs_pkg::CMD_READ, 8'd255, 14'd129, 0, 0, 0, 0, 0, 0);
		add_row(0, 0, lbcs_pkg::CMD_CLEAR, 8'd255, 0, 0, 0, 0, 0, 0, 0);
		add_row(0, 0, lbcs_pkg::CMD_READ, 8'd255, 14'd129, 0, 0, 0, 0, 0, 0);
		add_row(0, 0, lbcs_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(0, 0, CMD_BAD_LO, 8'hFF, 14'h3FFF, 15'h7FFF, 8'hFF, 1, lbcs_pkg::ST_OK, 0, 0);
		add_row(0, 0, CMD_BAD_HI, 8'hFF, 14'h3FFF, 15'h7FFF, 8'hFF, 1, lbcs_pkg::ST_OK, 0, 0);
		// scan limit of one while block 0 is taken; zero finds nothing
		add_row(1, 9'd1, lbcs_pkg::CMD_ALLOC, 0, 0, 0, 0, 1, lbcs_pkg::ST_NO_FREE, 0, 0);
		add_row(1, 9'd0, lbcs_pkg::CMD_ALLOC, 0, 0, 0, 0, 1, lbcs_pkg::ST_NO_FREE, 0, 0);
		add_row(1, 9'd3, lbcs_pkg::CMD_SETLEN, 8'd1, 0, 15'd200, 0, 0, 0, 0, 0);
		add_row(1, 9'h1FF, lbcs_pkg::CMD_ALLOC, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(0, 0, lbcs_pkg::CMD_SETLEN, 8'd1, 0, 15'd64, 0, 0, 0, 0, 0);
		add_row(1, lbcs_pkg::BIU_RESET, lbcs_pkg::CMD_SETLEN, 8'd7, 0, 15'd65, 0, 0, 0, 0, 0);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			if (rows[i].do_cfg) write_limit(rows[i].cfg);
			send(rows[i].r, rows[i].pinned, rows[i].typed);
		end
		for (int i = 0; i < 8; i++) heads.push_back(8'(i));
		heads.push_back(8'd255);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 300 == 299) begin
				pick = $urandom_range(3);
				write_limit(pick == 0 ? 9'd1 : pick == 1 ? 9'd256 :
					pick == 2 ? 9'($urandom_range(2, 255)) : 9'($urandom_range(257, 511)));
			end
			r = '{command: 3'($urandom), head_blk: 8'($urandom), position: 14'($urandom),
				length: 15'($urandom), data_byte: 8'($urandom)};
			pick = $urandom_range(99);
			if (pick >= 10) begin
				r.head_blk = heads[$urandom_range(heads.size() - 1)];
				if (pick < 17) begin
					r.command = lbcs_pkg::CMD_ALLOC;
				end else if (pick < 37) begin
					r.command = lbcs_pkg::CMD_SETLEN;
					r.length = $urandom_range(99) == 0 ? 15'($urandom_range(16384)) :
						15'($urandom_range(640));
				end else if (pick < 95) begin
					r.command = pick < 65 ? lbcs_pkg::CMD_WRITE : lbcs_pkg::CMD_READ;
					if ($urandom_range(9) != 0) r.position = 14'($urandom_range(700));
				end else begin
					r.command = lbcs_pkg::CMD_CLEAR;
				end
			end
			send(r, 1'b0, '0);
		end
		start <= 1'b0;
		@(posedge clk);
		while (pending_q.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		$display("%0d items run, %0d results checked, scan limit swept 0..511,",
			n_items, results_seen);
		$display("chains grown, cut, cleared and walked past their end");
		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	// heads of freshly allocated chains feed later commands
	always @(posedge clk) begin
		if (done && rsp.status == lbcs_pkg::ST_OK && rsp.block_index != 0 && heads.size() < 64)
			heads.push_back(rsp.block_index);
	end

endmodule
